// File: design/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Types and constants shared by the streaming KMP matcher and its channels.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int CHAR_BITS = 8;
  localparam int OUT_BITS  = 32;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t            req_type;
    logic [CHAR_BITS-1:0] char_value;
    logic                 start_new;
  } req_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] match_start;
  } rsp_t;

endpackage

// File: design/kms_stream_if.sv
// ----------------------------------------------------------------------------
// kms_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface kms_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: design/kms_ram.sv
// ----------------------------------------------------------------------------
// kms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/kmp_stream_matcher.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt search over pattern and text byte transfers.
// ----------------------------------------------------------------------------
// Pattern bytes are appended to a pattern RAM while the failure table RAM is
// extended one entry per byte; text bytes advance the matched count and every
// full match, overlapping ones included, returns the text position where it
// begins. One item is in work at a time. The first pattern byte, a pattern
// byte beyond MAX_PAT and a text byte against an empty pattern finish as
// they are accepted. Any other byte enters a lookup state that follows one
// failure-table fallback per registered read of both RAMs. A match is held
// until the result register is free.
// ----------------------------------------------------------------------------
module kmp_stream_matcher #(
  parameter int MAX_PAT  = 64,
  parameter int POS_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  kms_stream_if.sink    req,
  kms_stream_if.source  rsp
);

  import kms_pkg::*;

  localparam int CW = $clog2(MAX_PAT + 1);
  localparam int AW = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int WB = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t               state;
  logic [CW-1:0]        k;
  logic [CW-1:0]        len;
  logic [CW-1:0]        pbc;
  logic [CW-1:0]        tmc;
  logic [POS_BITS-1:0]  pos;
  logic [POS_BITS-1:0]  idx;
  logic [CHAR_BITS-1:0] chr;
  logic                 is_text;
  logic                 out_valid;
  logic [OUT_BITS-1:0]  out_data;

  logic                 in_fire;
  logic                 fresh;
  logic                 text;
  logic [CW-1:0]        len_eff;
  logic [CW-1:0]        pbc_eff;
  logic [CW-1:0]        tmc_eff;
  logic [CW-1:0]        k0;
  logic [POS_BITS-1:0]  pos_cur;
  logic                 need_loop;

  logic [CHAR_BITS-1:0] pat_rd;
  logic [CW-1:0]        fail_rd;
  logic [CW-1:0]        rd_k;
  logic [CW-1:0]        rd_km1;
  logic                 hit;
  logic                 step;
  logic [CW-1:0]        kn;
  logic                 match;
  logic                 out_free;
  logic                 done;

  logic                 pat_we;
  logic                 fail_we;
  logic [AW-1:0]        fail_waddr;
  logic [CW-1:0]        fail_wdata;
  logic [WB-1:0]        start_wide;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign fresh     = req.data.start_new;
  assign text      = (req.data.req_type == REQ_TEXT);

  assign len_eff = (!text && fresh) ? '0 : len;
  assign pbc_eff = fresh ? '0 : pbc;
  assign tmc_eff = fresh ? '0 : tmc;
  assign pos_cur = fresh ? '0 : pos;

  always_comb begin
    if (!text) begin
      k0 = pbc_eff;
    end else if (tmc_eff >= len) begin
      k0 = '0;
    end else begin
      k0 = tmc_eff;
    end
  end

  always_comb begin
    if (text) begin
      need_loop = (len != '0);
    end else begin
      need_loop = (len_eff != '0) && (len_eff < CW'(MAX_PAT));
    end
  end

  assign hit      = (pat_rd == chr);
  assign step     = !hit && (k != '0);
  assign kn       = hit ? (k + CW'(1)) : '0;
  assign match    = is_text && (kn == len);
  assign out_free = !out_valid || rsp.ready;
  assign done     = (state == S_LOOK) && !step && (!match || out_free);

  always_comb begin
    if (state == S_IDLE) begin
      rd_k = k0;
    end else if (step) begin
      rd_k = fail_rd;
    end else begin
      rd_k = k;
    end
  end
  assign rd_km1 = rd_k - CW'(1);

  assign pat_we = in_fire && !text && (len_eff < CW'(MAX_PAT));

  always_comb begin
    fail_we    = 1'b0;
    fail_waddr = len[AW-1:0];
    fail_wdata = kn;
    if (in_fire && !text && (len_eff == '0)) begin
      fail_we    = 1'b1;
      fail_waddr = '0;
      fail_wdata = '0;
    end else if (done && !is_text) begin
      fail_we = 1'b1;
    end
  end

  assign start_wide = WB'(idx) - WB'(len - CW'(1));

  kms_ram #(
    .WIDTH (CHAR_BITS),
    .DEPTH (MAX_PAT)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (len_eff[AW-1:0]),
    .wdata (req.data.char_value),
    .raddr (rd_k[AW-1:0]),
    .rdata (pat_rd)
  );

  kms_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_PAT)
  ) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (fail_waddr),
    .wdata (fail_wdata),
    .raddr (rd_km1[AW-1:0]),
    .rdata (fail_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      pbc       <= '0;
      tmc       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            chr     <= req.data.char_value;
            is_text <= text;
            k       <= k0;
            if (text) begin
              idx <= pos_cur;
              tmc <= tmc_eff;
              pos <= (pos_cur != '1) ? (pos_cur + POS_BITS'(1)) : pos_cur;
            end else begin
              if (fresh) begin
                tmc <= '0;
                pos <= '0;
              end
              len <= len_eff;
              pbc <= pbc_eff;
              if (len_eff == '0) begin
                len <= CW'(1);
                pbc <= '0;
              end
            end
            if (need_loop) begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (step) begin
            k <= fail_rd;
          end else if (done) begin
            state <= S_IDLE;
            if (is_text) begin
              if (match) begin
                tmc       <= pbc;
                out_valid <= 1'b1;
                out_data  <= start_wide[OUT_BITS-1:0];
              end else begin
                tmc <= kn;
              end
            end else begin
              pbc <= kn;
              len <= len + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.data.match_start = out_data;

endmodule
